// ----- rtl/bte_pkg.sv -----
// Shared types, codes, constants and helper functions for the body temperature estimator.
`timescale 1ns / 1ps

package bte_pkg;

    typedef logic [1:0]         t_op;
    typedef logic [1:0]         t_status;
    typedef logic signed [14:0] t_temp;

    // Partial results of the calibration curve for one temperature
    typedef struct packed {
        logic        hi;     // 36.00 < t <= 41.00
        logic        mid;    // 28.00 < t <= 36.00
        logic [15:0] m82;    // (t - 3600) * 82
        logic [6:0]  q10;    // (t - 2800) / 10
    } t_curve_part;

    // Operation codes on the input stream
    localparam t_op OP_SAMPLE  = 2'd0;
    localparam t_op OP_RESTART = 2'd1;
    localparam t_op OP_STOP    = 2'd2;

    // Result status codes
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NO_CONTACT = 2'd1;
    localparam t_status ST_CRC_ERR    = 2'd2;

    // Register indexes
    localparam logic REG_CRC_EN = 1'b0;

    // CRC-8 settings
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Code to centidegree conversion: 17500 * code / 65535 - 4500
    localparam logic [30:0]        SKIN_SPAN   = 31'd17500;
    localparam logic signed [15:0] SKIN_OFFSET = 16'sd4500;
    localparam logic signed [15:0] SKIN_LIMIT  = 16'sd9990;

    // Warm counter
    localparam int          COUNT_W     = 11;
    localparam logic [10:0] COUNT_MAX   = 11'd2000;
    localparam logic [10:0] LATCH_COUNT = 11'd20;
    localparam logic [10:0] RAMP_MID    = 11'd25;
    localparam logic [10:0] RAMP_END    = 11'd30;
    localparam t_temp       WARM_LIMIT  = 15'sd2800;

    // Calibration curve breakpoints and offsets
    localparam t_temp CURVE_LO   = 15'sd2800;
    localparam t_temp CURVE_MID  = 15'sd3600;
    localparam t_temp CURVE_HI   = 15'sd4100;
    localparam t_temp CURVE_BASE_MID = 15'sd3610;
    localparam t_temp CURVE_BASE_HI  = 15'sd3690;
    localparam logic [15:0] CURVE_SLOPE = 16'd82;

    // Reciprocals: x/10 = x*6554>>16 (x <= 800), x/100 = x*5243>>19 (x <= 41000),
    // x/25 = x*20972>>19 (x < 43690)
    localparam logic [22:0] RECIP_10  = 23'd6554;
    localparam logic [28:0] RECIP_100 = 29'd5243;
    localparam logic [29:0] RECIP_25  = 30'd20972;

    // One byte through the CRC-8 shift register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    // First half of the curve: range flags and the two scaled offsets
    function automatic t_curve_part curve_part(input t_temp t);
        t_curve_part p;
        t_temp       a;
        t_temp       b;
        logic [22:0] m10;
        a     = t - CURVE_MID;
        b     = t - CURVE_LO;
        p.hi  = (t > CURVE_MID) && (t <= CURVE_HI);
        p.mid = (t > CURVE_LO) && (t <= CURVE_MID);
        p.m82 = {7'd0, a[8:0]} * CURVE_SLOPE;
        m10   = {13'd0, b[9:0]} * RECIP_10;
        p.q10 = m10[22:16];
        return p;
    endfunction

    // Second half of the curve: divide by 100 and pick the segment
    function automatic t_temp curve_finish(input t_curve_part p, input t_temp t);
        logic [28:0] m100;
        t_temp       r;
        m100 = {13'd0, p.m82} * RECIP_100;
        if (p.hi) begin
            r = CURVE_BASE_HI + t_temp'({5'd0, m100[28:19]});
        end else if (p.mid) begin
            r = CURVE_BASE_MID + t_temp'({8'd0, p.q10});
        end else begin
            r = t;
        end
        return r;
    endfunction

endpackage

// ----- rtl/body_temperature_estimator.sv -----
// Body temperature estimator: skin temperature conversion, warm counter and body estimate.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one item per transfer. tuser carries the op (sample, restart,
//   stop); tdata carries the raw code, its CRC byte and the skin-contact flag.
//   Master stream: one result per input item, in order. tuser carries the status;
//   tdata carries skin temperature, body estimate and the ready flag.
//   APB port: register 0 at address 0 enables the CRC-8 check (reset 1).
//   Throughput: one item per cycle while results are taken; the stage registers
//   A to F and the output register each hold one item and close up bubbles, so
//   o_s_tready stays high while any stage is free.
//   The warm counter and latched prediction are updated as an item leaves the
//   second stage, so the following item always sees them.
//   When the receiver stalls, the pipeline fills and then o_s_tready drops; no
//   result is lost or repeated.
//   Reset clears the pipeline, the counter and the latched prediction, and sets
//   the CRC check enable.
module body_temperature_estimator
    import bte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] raw_code, [23:16] raw_crc, [24] skin_contact
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [14:0] skin_temp, [29:15] body_temp, [30] body_ready
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // Configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    // Estimate paths
    localparam logic [1:0] P_SKIN  = 2'd0;
    localparam logic [1:0] P_UP    = 2'd1;
    localparam logic [1:0] P_DOWN  = 2'd2;
    localparam logic [1:0] P_CURVE = 2'd3;

    // Configuration register
    logic r_crc_en;

    // Estimator state
    logic [COUNT_W-1:0] r_warm_cnt, n_warm_cnt;
    t_temp              r_lat, n_lat;
    logic               r_pvld, n_pvld;

    // Stage A: input register
    logic        r_a_vld;
    t_op         r_a_op;
    logic [15:0] r_a_code;
    logic [7:0]  r_a_crc;
    logic        r_a_contact;

    // Stage B: product and decoded op
    logic        r_b_vld;
    logic [30:0] r_b_prod;
    t_status     r_b_sts;
    logic        r_b_use, r_b_rst, r_b_stp;

    // Stage C: skin temperature and path
    logic        r_c_vld;
    t_temp       r_c_skin, r_c_lat;
    logic        r_c_pvld;
    logic [1:0]  r_c_path;
    logic [4:0]  r_c_k;
    t_status     r_c_sts;
    logic        r_c_use;

    // Stage D: curve partials for skin (0) and latched temperature (1)
    logic        r_d_vld;
    t_curve_part r_d_part [2];
    t_temp       r_d_skin, r_d_lat;
    logic        r_d_pvld;
    logic [1:0]  r_d_path;
    logic [4:0]  r_d_k;
    t_status     r_d_sts;
    logic        r_d_use;

    // Stage E: curve values
    logic        r_e_vld;
    t_temp       r_e_skin, r_e_lat, r_e_p, r_e_cs;
    logic [1:0]  r_e_path;
    logic [4:0]  r_e_k;
    t_status     r_e_sts;
    logic        r_e_use;

    // Stage F: ramp step product
    logic        r_f_vld;
    logic [14:0] r_f_kd;
    t_temp       r_f_skin, r_f_lat, r_f_p, r_f_cs;
    logic [1:0]  r_f_path;
    t_status     r_f_sts;
    logic        r_f_use;

    // Output register
    logic        r_o_vld;
    t_status     r_o_sts;
    t_temp       r_o_skin, r_o_body;
    logic        r_o_rdy;

    // Stage enables: a stage loads when empty or when its item moves on
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_o;
    logic fire_b;

    assign rdy_o  = !r_o_vld || i_m_tready;
    assign rdy_f  = !r_f_vld || rdy_o;
    assign rdy_e  = !r_e_vld || rdy_f;
    assign rdy_d  = !r_d_vld || rdy_e;
    assign rdy_c  = !r_c_vld || rdy_d;
    assign rdy_b  = !r_b_vld || rdy_c;
    assign rdy_a  = !r_a_vld || rdy_b;
    assign fire_b = r_b_vld && rdy_c;

    assign o_s_tready = rdy_a;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_s_tvalid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            if (rdy_e) r_e_vld <= r_d_vld;
            if (rdy_f) r_f_vld <= r_e_vld;
            if (rdy_o) r_o_vld <= r_f_vld;
        end
    end

    // Configuration write and read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && o_pready && (i_paddr[2] == REG_CRC_EN)) begin
            r_crc_en <= i_pwdata[0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_CRC_EN) ? {31'd0, r_crc_en} : 32'd0;

    // Stage A capture
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_op      <= i_s_tuser;
            r_a_code    <= i_s_tdata[15:0];
            r_a_crc     <= i_s_tdata[23:16];
            r_a_contact <= i_s_tdata[24];
        end
    end

    // Stage A: CRC check, op decode, scale product
    logic [7:0]  w_crc;
    t_status     n_b_sts;
    logic        n_b_use, n_b_rst, n_b_stp;
    logic [30:0] w_prod;

    assign w_crc  = crc8_byte(crc8_byte(CRC_INIT, r_a_code[15:8]), r_a_code[7:0]);
    assign w_prod = {15'd0, r_a_code} * SKIN_SPAN;

    always_comb begin
        n_b_sts = ST_OK;
        n_b_use = 1'b0;
        n_b_rst = 1'b0;
        n_b_stp = 1'b0;
        case (r_a_op)
            OP_SAMPLE: begin
                if (!r_a_contact) begin
                    n_b_sts = ST_NO_CONTACT;
                end else if (r_crc_en && (w_crc != r_a_crc)) begin
                    n_b_sts = ST_CRC_ERR;
                end else begin
                    n_b_use = 1'b1;
                end
            end
            OP_RESTART: n_b_rst = 1'b1;
            OP_STOP:    n_b_stp = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_prod <= w_prod;
            r_b_sts  <= n_b_sts;
            r_b_use  <= n_b_use;
            r_b_rst  <= n_b_rst;
            r_b_stp  <= n_b_stp;
        end
    end

    // Stage B: divide by 65535 as (x + (x >> 16) + 1) >> 16, offset, zero above SKIN_LIMIT
    logic [31:0]        w_sum;
    logic signed [15:0] w_skin_raw;
    t_temp              n_c_skin;
    logic [COUNT_W-1:0] w_ofs, w_dn;
    logic [1:0]         n_c_path;
    logic [4:0]         n_c_k;

    assign w_sum      = {1'b0, r_b_prod} + {17'd0, r_b_prod[30:16]} + 32'd1;
    assign w_skin_raw = signed'({1'b0, w_sum[30:16]}) - SKIN_OFFSET;
    assign n_c_skin   = (w_skin_raw > SKIN_LIMIT) ? '0 : w_skin_raw[14:0];

    // Warm counter, latch and prediction flag
    always_comb begin
        n_warm_cnt = r_warm_cnt;
        n_lat      = r_lat;
        n_pvld     = r_pvld;
        if (r_b_rst) begin
            n_warm_cnt = '0;
            n_lat      = '0;
            n_pvld     = 1'b0;
        end else if (r_b_stp) begin
            n_warm_cnt = '0;
        end else if (r_b_use) begin
            if (n_c_skin > WARM_LIMIT) begin
                if (r_warm_cnt < COUNT_MAX) n_warm_cnt = r_warm_cnt + 1'b1;
            end else if (r_warm_cnt != COUNT_MAX) begin
                n_warm_cnt = '0;
            end
            if (n_warm_cnt == '0) n_pvld = 1'b0;
            if (n_warm_cnt == LATCH_COUNT) begin
                n_lat  = n_c_skin;
                n_pvld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_cnt <= '0;
            r_lat      <= '0;
            r_pvld     <= 1'b0;
        end else if (fire_b) begin
            r_warm_cnt <= n_warm_cnt;
            r_lat      <= n_lat;
            r_pvld     <= n_pvld;
        end
    end

    // Path select and ramp weight from the updated count
    assign w_ofs = n_warm_cnt - LATCH_COUNT;
    assign w_dn  = RAMP_END - n_warm_cnt;

    always_comb begin
        if (n_warm_cnt <= LATCH_COUNT) begin
            n_c_path = P_SKIN;
            n_c_k    = '0;
        end else if (n_warm_cnt <= RAMP_MID) begin
            n_c_path = P_UP;
            n_c_k    = {w_ofs[2:0], 2'b00};
        end else if (n_warm_cnt <= RAMP_END) begin
            n_c_path = P_DOWN;
            n_c_k    = {2'b00, w_dn[2:0]};
        end else begin
            n_c_path = P_CURVE;
            n_c_k    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_skin <= n_c_skin;
            r_c_lat  <= n_lat;
            r_c_pvld <= n_pvld;
            r_c_path <= n_c_path;
            r_c_k    <= n_c_k;
            r_c_sts  <= r_b_sts;
            r_c_use  <= r_b_use;
        end
    end

    // Stage C: curve partials
    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_part[0] <= curve_part(r_c_skin);
            r_d_part[1] <= curve_part(r_c_lat);
            r_d_skin    <= r_c_skin;
            r_d_lat     <= r_c_lat;
            r_d_pvld    <= r_c_pvld;
            r_d_path    <= r_c_path;
            r_d_k       <= r_c_k;
            r_d_sts     <= r_c_sts;
            r_d_use     <= r_c_use;
        end
    end

    // Stage D: finish curve for skin and prediction
    t_temp w_p;

    assign w_p = r_d_pvld ? curve_finish(r_d_part[1], r_d_lat) : '0;

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_e_cs   <= curve_finish(r_d_part[0], r_d_skin);
            r_e_p    <= w_p;
            r_e_skin <= r_d_skin;
            r_e_lat  <= r_d_lat;
            r_e_path <= r_d_path;
            r_e_k    <= r_d_k;
            r_e_sts  <= r_d_sts;
            r_e_use  <= r_d_use;
        end
    end

    // Stage E: ramp weight times prediction gap (gap is 0..809)
    t_temp       w_diff;
    logic [14:0] w_kd;

    assign w_diff = r_e_p - r_e_lat;
    assign w_kd   = {10'd0, r_e_k} * {5'd0, w_diff[9:0]};

    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            r_f_kd   <= w_kd;
            r_f_skin <= r_e_skin;
            r_f_lat  <= r_e_lat;
            r_f_p    <= r_e_p;
            r_f_cs   <= r_e_cs;
            r_f_path <= r_e_path;
            r_f_sts  <= r_e_sts;
            r_f_use  <= r_e_use;
        end
    end

    // Stage F: divide by 25 and pick the estimate
    logic [29:0] w_m25;
    t_temp       w_q25;
    t_temp       n_o_body;
    logic        n_o_rdy;

    assign w_m25 = {15'd0, r_f_kd} * RECIP_25;
    assign w_q25 = t_temp'({4'd0, w_m25[29:19]});

    always_comb begin
        n_o_rdy = 1'b0;
        case (r_f_path)
            P_SKIN:  n_o_body = r_f_skin;
            P_UP:    n_o_body = r_f_lat + w_q25;
            P_DOWN:  n_o_body = r_f_p - w_q25;
            P_CURVE: begin
                n_o_body = r_f_cs;
                n_o_rdy  = 1'b1;
            end
            default: n_o_body = r_f_skin;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_sts  <= r_f_sts;
            r_o_skin <= r_f_use ? r_f_skin : '0;
            r_o_body <= r_f_use ? n_o_body : '0;
            r_o_rdy  <= r_f_use && n_o_rdy;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tuser  = r_o_sts;
    assign o_m_tdata  = {1'b0, r_o_rdy, r_o_body, r_o_skin};

    // Checks
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warm_cnt <= COUNT_MAX)
        else $error("warm counter beyond saturation");

    a_ramp_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_c_use && (r_c_path == P_UP || r_c_path == P_DOWN)) |-> r_c_pvld)
        else $error("ramp without a latched prediction");

    a_pred_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && r_e_use && (r_e_path == P_UP || r_e_path == P_DOWN)) |-> (r_e_p >= r_e_lat))
        else $error("prediction below latched temperature");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire_b && r_b_rst) |=> (r_warm_cnt == '0 && r_lat == '0 && !r_pvld))
        else $error("restart did not clear estimator state");

endmodule
